// ----- src/soa_pkg.sv -----
// ----------------------------------------------------------------------------
// Slab object allocator package
// Shared constants, codes, types and class geometry tables for the allocator.
// ----------------------------------------------------------------------------
package soa_pkg;

   localparam int NUM_PAGES   = 64;
   localparam int PAGE_W      = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
   localparam int CLAIM_W     = $clog2(NUM_PAGES + 1);
   localparam int NUM_CLASSES = 9;
   localparam int CLASS_W     = 4;
   localparam int SLOT_W      = 9;
   localparam int LINK_W      = 10;
   localparam int NF_AW       = PAGE_W + SLOT_W;

   localparam logic [LINK_W-1:0]  LIST_END   = 10'h3FF;
   localparam logic [CLASS_W-1:0] CLASS_NONE = 4'd15;
   localparam logic [15:0]        MAX_SMALL  = 16'd2048;

   typedef enum logic [3:0] {
      ST_ALLOCATED   = 4'd0,
      ST_FREED       = 4'd1,
      ST_ZERO_SIZE   = 4'd2,
      ST_TOO_LARGE   = 4'd3,
      ST_NO_CLASS    = 4'd4,
      ST_POOL_FULL   = 4'd5,
      ST_NOT_SLAB    = 4'd6,
      ST_MISALIGNED  = 4'd7,
      ST_BAD_INDEX   = 4'd8,
      ST_DOUBLE_FREE = 4'd9
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_A_SCAN_RD,
      S_A_SCAN_CHK,
      S_A_INIT,
      S_A_POP_RD,
      S_A_POP_WR,
      S_F_META_RD,
      S_F_CHECK,
      S_F_WALK_CHK,
      S_F_WALK_WAIT,
      S_F_PUSH
   } state_type;

   typedef struct packed {
      logic               hit;
      logic [CLASS_W-1:0] cls;
   } class_sel_type;

   typedef struct packed {
      logic [CLASS_W-1:0] cls;
      logic [LINK_W-1:0]  head;
      logic [LINK_W-1:0]  used;
   } page_meta_type;

   // Header size, the 24-byte header rounded up to the object size.
   function automatic logic [11:0] class_hdr(input logic [CLASS_W-1:0] cls);
      logic [11:0] h;
      case (cls)
         4'd0:    h = 12'd24;
         4'd1:    h = 12'd32;
         4'd2:    h = 12'd32;
         4'd3:    h = 12'd64;
         4'd4:    h = 12'd128;
         4'd5:    h = 12'd256;
         4'd6:    h = 12'd512;
         4'd7:    h = 12'd1024;
         4'd8:    h = 12'd2048;
         default: h = 12'd0;
      endcase
      return h;
   endfunction

   // Objects per page after the header.
   function automatic logic [LINK_W-1:0] class_cap(input logic [CLASS_W-1:0] cls);
      logic [LINK_W-1:0] c;
      case (cls)
         4'd0:    c = 10'd509;
         4'd1:    c = 10'd254;
         4'd2:    c = 10'd127;
         4'd3:    c = 10'd63;
         4'd4:    c = 10'd31;
         4'd5:    c = 10'd15;
         4'd6:    c = 10'd7;
         4'd7:    c = 10'd3;
         4'd8:    c = 10'd1;
         default: c = 10'd1;
      endcase
      return c;
   endfunction

endpackage

// ----- src/soa_class_select.sv -----
// ----------------------------------------------------------------------------
// Slab allocator size class selection
// Picks the first power-of-two class that holds the size and meets alignment.
// ----------------------------------------------------------------------------
module soa_class_select (
   input  logic [15:0]                   size,
   input  logic [12:0]                   alignment,
   output soa_pkg::class_sel_type        sel
);

   logic [12:0] align_eff;
   logic        align_pow2;
   logic [16:0] csize;

   assign align_eff  = (alignment == 13'd0) ? 13'd1 : alignment;
   assign align_pow2 = ((align_eff & (align_eff - 13'd1)) == 13'd0);

   // A power-of-two class is divisible by the alignment exactly when the
   // alignment is a power of two no larger than the class.
   always_comb begin
      sel.hit = 1'b0;
      sel.cls = soa_pkg::CLASS_NONE;
      csize   = 17'd0;
      for (int c = soa_pkg::NUM_CLASSES - 1; c >= 0; c--) begin
         csize = 17'd8 << c;
         if (csize >= {1'b0, size} && align_pow2 && {4'd0, align_eff} <= csize) begin
            sel.hit = 1'b1;
            sel.cls = soa_pkg::CLASS_W'(c);
         end
      end
   end

endmodule

// ----- src/slab_object_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// Slab object allocator unit
// Allocates and frees small objects from a pool of 4 KiB pages split into
// nine power-of-two size classes, each page keeping a LIFO free list.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Payload
//   req      in         start high, busy low   opcode, size, alignment, addr
//   rsp      out        rsp_valid, one cycle   status, object_address
//   csr      in         csr_valid & csr_ready  pool_base write data
//
// A request that is rejected by its first checks answers in the cycle after
// it is taken. An allocate scans claimed pages newest first, one metadata
// read per page; a fresh page builds its free list one object at a time (up
// to 509); a free walks the page's free list, one link read at a time, to
// find double frees. Registered reads of the metadata and free-list memories
// pace these steps. Reset clears the pool base, the claimed-page count and
// the sequencer; no clearing pass is run.
// The receiver cannot stall: each beat on rsp is shown for one cycle only.
//
module slab_object_allocator_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_opcode,
   input  logic [15:0] req_request_size,
   input  logic [12:0] req_alignment,
   input  logic [31:0] req_free_address,
   output logic        rsp_valid,
   output logic [3:0]  rsp_status,
   output logic [31:0] rsp_object_address,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_write_data
);

   localparam int PW = soa_pkg::PAGE_W;
   localparam int CW = soa_pkg::CLAIM_W;
   localparam int LW = soa_pkg::LINK_W;
   localparam int SW = soa_pkg::SLOT_W;
   localparam int AW = soa_pkg::NF_AW;

   // Registers.
   soa_pkg::state_type  state_ff, state_in;
   logic [31:0]         pool_base_ff;
   logic [CW-1:0]       claimed_ff;
   logic [CW-1:0]       scan_ff;
   logic [PW-1:0]       page_ff;
   logic [11:0]         inpage_ff;
   logic [soa_pkg::CLASS_W-1:0] cls_ff;
   logic [LW-1:0]       head_ff;
   logic [LW-1:0]       used_ff;
   logic [LW-1:0]       cnt_ff;
   logic [LW-1:0]       cur_ff;
   logic [SW-1:0]       idx_ff;
   logic                rsp_valid_ff;
   logic [3:0]          rsp_status_ff;
   logic [31:0]         rsp_addr_ff;

   // Memories: per-page metadata and the per-object free-list links.
   soa_pkg::page_meta_type meta_mem [soa_pkg::NUM_PAGES];
   soa_pkg::page_meta_type meta_rd_ff;
   logic [LW-1:0]          nf_mem [2**AW];
   logic [LW-1:0]          nf_rd_ff;

   // Memory control from the output decode.
   logic                   meta_we;
   logic [PW-1:0]          meta_waddr, meta_raddr;
   soa_pkg::page_meta_type meta_wdata;
   logic                   nf_we;
   logic [AW-1:0]          nf_waddr, nf_raddr;
   logic [LW-1:0]          nf_wdata;
   logic                   finish;
   soa_pkg::status_type    fin_status;
   logic [31:0]            fin_addr;

   // Shared datapath terms.
   soa_pkg::class_sel_type sel;
   logic                   accept;
   logic [31:0]            req_off;
   logic                   req_page_out;
   logic [LW-1:0]          cap_cur;
   logic [11:0]            hdr_cur;
   logic [4:0]             shift_cur;
   logic [11:0]            mask_cur;
   logic [11:0]            rel;
   logic [11:0]            idx_full;
   logic [LW-1:0]          init_next;
   logic                   scan_hit;
   logic [CW-1:0]          scan_dec;
   soa_pkg::class_sel_type chk_cls;
   logic [11:0]            obj_off;

   soa_class_select u_class_select (
      .size      (req_request_size),
      .alignment (req_alignment),
      .sel       (sel)
   );

   assign accept       = start && (state_ff == soa_pkg::S_IDLE);
   assign busy         = (state_ff != soa_pkg::S_IDLE);
   assign csr_ready    = 1'b1;
   assign req_off      = req_free_address - {pool_base_ff[31:12], 12'd0};
   assign req_page_out = (req_off[31:12] >= 20'(claimed_ff));

   // In the free check the class comes from the page just read, otherwise
   // from the class held for this request.
   assign chk_cls.hit = (meta_rd_ff.cls < soa_pkg::CLASS_W'(soa_pkg::NUM_CLASSES));
   assign chk_cls.cls = (state_ff == soa_pkg::S_F_CHECK) ? meta_rd_ff.cls : cls_ff;
   assign cap_cur     = soa_pkg::class_cap(chk_cls.cls);
   assign hdr_cur     = soa_pkg::class_hdr(chk_cls.cls);
   assign shift_cur   = {1'b0, chk_cls.cls} + 5'd3;
   assign mask_cur    = (12'd1 << shift_cur) - 12'd1;
   assign rel         = inpage_ff - hdr_cur;
   assign idx_full    = rel >> shift_cur;
   assign init_next   = cnt_ff + LW'(1);
   assign scan_dec    = scan_ff - CW'(1);
   assign scan_hit    = (meta_rd_ff.cls == cls_ff) && (meta_rd_ff.head != soa_pkg::LIST_END);
   assign obj_off     = hdr_cur + (12'(head_ff[SW-1:0]) << shift_cur);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         soa_pkg::S_IDLE: begin
            if (accept) begin
               if (!req_opcode) begin
                  if (req_request_size != 16'd0 && req_request_size <= soa_pkg::MAX_SMALL
                      && sel.hit) begin
                     state_in = soa_pkg::S_A_SCAN_RD;
                  end
               end else if (req_free_address != 32'd0 && !req_page_out) begin
                  state_in = soa_pkg::S_F_META_RD;
               end
            end
         end
         soa_pkg::S_A_SCAN_RD: begin
            if (scan_ff != CW'(0)) begin
               state_in = soa_pkg::S_A_SCAN_CHK;
            end else if (claimed_ff >= CW'(soa_pkg::NUM_PAGES)) begin
               state_in = soa_pkg::S_IDLE;
            end else begin
               state_in = soa_pkg::S_A_INIT;
            end
         end
         soa_pkg::S_A_SCAN_CHK: begin
            state_in = scan_hit ? soa_pkg::S_A_POP_RD : soa_pkg::S_A_SCAN_RD;
         end
         soa_pkg::S_A_INIT: begin
            if (init_next == cap_cur) begin
               state_in = soa_pkg::S_A_POP_RD;
            end
         end
         soa_pkg::S_A_POP_RD:  state_in = soa_pkg::S_A_POP_WR;
         soa_pkg::S_A_POP_WR:  state_in = soa_pkg::S_IDLE;
         soa_pkg::S_F_META_RD: state_in = soa_pkg::S_F_CHECK;
         soa_pkg::S_F_CHECK: begin
            if (!chk_cls.hit || (inpage_ff & mask_cur) != 12'd0 || inpage_ff < hdr_cur
                || idx_full >= 12'(cap_cur) || meta_rd_ff.used == LW'(0)) begin
               state_in = soa_pkg::S_IDLE;
            end else begin
               state_in = soa_pkg::S_F_WALK_CHK;
            end
         end
         soa_pkg::S_F_WALK_CHK: begin
            if (cur_ff == soa_pkg::LIST_END || cnt_ff >= cap_cur) begin
               state_in = soa_pkg::S_F_PUSH;
            end else if (cur_ff == LW'(idx_ff)) begin
               state_in = soa_pkg::S_IDLE;
            end else begin
               state_in = soa_pkg::S_F_WALK_WAIT;
            end
         end
         soa_pkg::S_F_WALK_WAIT: state_in = soa_pkg::S_F_WALK_CHK;
         soa_pkg::S_F_PUSH:      state_in = soa_pkg::S_IDLE;
         default:                state_in = soa_pkg::S_IDLE;
      endcase
   end

   // Outputs: memory strobes and the finishing beat.
   always_comb begin
      meta_we    = 1'b0;
      meta_waddr = page_ff;
      meta_wdata = '{cls: cls_ff, head: head_ff, used: used_ff};
      meta_raddr = page_ff;
      nf_we      = 1'b0;
      nf_waddr   = {page_ff, cnt_ff[SW-1:0]};
      nf_wdata   = (init_next < cap_cur) ? init_next : soa_pkg::LIST_END;
      nf_raddr   = {page_ff, head_ff[SW-1:0]};
      finish     = 1'b0;
      fin_status = soa_pkg::ST_ALLOCATED;
      fin_addr   = 32'd0;
      case (state_ff)
         soa_pkg::S_IDLE: begin
            if (accept) begin
               if (!req_opcode) begin
                  if (req_request_size == 16'd0) begin
                     finish     = 1'b1;
                     fin_status = soa_pkg::ST_ZERO_SIZE;
                  end else if (req_request_size > soa_pkg::MAX_SMALL) begin
                     finish     = 1'b1;
                     fin_status = soa_pkg::ST_TOO_LARGE;
                  end else if (!sel.hit) begin
                     finish     = 1'b1;
                     fin_status = soa_pkg::ST_NO_CLASS;
                  end
               end else if (req_free_address == 32'd0 || req_page_out) begin
                  finish     = 1'b1;
                  fin_status = soa_pkg::ST_NOT_SLAB;
               end
            end
         end
         soa_pkg::S_A_SCAN_RD: begin
            meta_raddr = scan_dec[PW-1:0];
            if (scan_ff == CW'(0)) begin
               if (claimed_ff >= CW'(soa_pkg::NUM_PAGES)) begin
                  finish     = 1'b1;
                  fin_status = soa_pkg::ST_POOL_FULL;
               end else begin
                  // Claim the next fresh page with an empty in-use count.
                  meta_we    = 1'b1;
                  meta_waddr = claimed_ff[PW-1:0];
                  meta_wdata = '{cls: cls_ff, head: LW'(0), used: LW'(0)};
               end
            end
         end
         soa_pkg::S_A_INIT: begin
            nf_we = 1'b1;
         end
         soa_pkg::S_A_POP_WR: begin
            meta_we    = 1'b1;
            meta_wdata = '{cls: cls_ff, head: nf_rd_ff, used: used_ff + LW'(1)};
            finish     = 1'b1;
            fin_status = soa_pkg::ST_ALLOCATED;
            fin_addr   = {pool_base_ff[31:12] + 20'(page_ff), obj_off};
         end
         soa_pkg::S_F_CHECK: begin
            if (!chk_cls.hit) begin
               finish     = 1'b1;
               fin_status = soa_pkg::ST_NOT_SLAB;
            end else if ((inpage_ff & mask_cur) != 12'd0) begin
               finish     = 1'b1;
               fin_status = soa_pkg::ST_MISALIGNED;
            end else if (inpage_ff < hdr_cur || idx_full >= 12'(cap_cur)
                         || meta_rd_ff.used == LW'(0)) begin
               finish     = 1'b1;
               fin_status = soa_pkg::ST_BAD_INDEX;
            end
         end
         soa_pkg::S_F_WALK_CHK: begin
            nf_raddr = {page_ff, cur_ff[SW-1:0]};
            if (cur_ff != soa_pkg::LIST_END && cnt_ff < cap_cur && cur_ff == LW'(idx_ff)) begin
               finish     = 1'b1;
               fin_status = soa_pkg::ST_DOUBLE_FREE;
            end
         end
         soa_pkg::S_F_PUSH: begin
            nf_we      = 1'b1;
            nf_waddr   = {page_ff, idx_ff};
            nf_wdata   = head_ff;
            meta_we    = 1'b1;
            meta_wdata = '{cls: cls_ff, head: LW'(idx_ff), used: used_ff - LW'(1)};
            finish     = 1'b1;
            fin_status = soa_pkg::ST_FREED;
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= soa_pkg::S_IDLE;
         pool_base_ff <= 32'd0;
         claimed_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= finish;
         if (csr_valid && csr_ready) begin
            pool_base_ff <= csr_write_data;
         end
         if (state_ff == soa_pkg::S_A_SCAN_RD && scan_ff == CW'(0)
             && claimed_ff < CW'(soa_pkg::NUM_PAGES)) begin
            claimed_ff <= claimed_ff + CW'(1);
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_status_ff <= fin_status;
         rsp_addr_ff   <= fin_addr;
      end
      case (state_ff)
         soa_pkg::S_IDLE: begin
            cls_ff    <= sel.cls;
            scan_ff   <= claimed_ff;
            page_ff   <= req_off[12+PW-1:12];
            inpage_ff <= req_off[11:0];
         end
         soa_pkg::S_A_SCAN_RD: begin
            if (scan_ff == CW'(0)) begin
               page_ff <= claimed_ff[PW-1:0];
               head_ff <= LW'(0);
               used_ff <= LW'(0);
               cnt_ff  <= LW'(0);
            end
         end
         soa_pkg::S_A_SCAN_CHK: begin
            scan_ff <= scan_dec;
            if (scan_hit) begin
               page_ff <= scan_dec[PW-1:0];
               head_ff <= meta_rd_ff.head;
               used_ff <= meta_rd_ff.used;
            end
         end
         soa_pkg::S_A_INIT: begin
            cnt_ff <= init_next;
         end
         soa_pkg::S_F_CHECK: begin
            cls_ff  <= meta_rd_ff.cls;
            head_ff <= meta_rd_ff.head;
            used_ff <= meta_rd_ff.used;
            cur_ff  <= meta_rd_ff.head;
            cnt_ff  <= LW'(0);
            idx_ff  <= idx_full[SW-1:0];
         end
         soa_pkg::S_F_WALK_WAIT: begin
            cur_ff <= nf_rd_ff;
            cnt_ff <= cnt_ff + LW'(1);
         end
         default: begin
         end
      endcase
   end

   // Metadata memory, read data registered.
   always_ff @(posedge clock) begin
      if (meta_we) begin
         meta_mem[meta_waddr] <= meta_wdata;
      end
      meta_rd_ff <= meta_mem[meta_raddr];
   end

   // Free-list link memory, read data registered.
   always_ff @(posedge clock) begin
      if (nf_we) begin
         nf_mem[nf_waddr] <= nf_wdata;
      end
      nf_rd_ff <= nf_mem[nf_raddr];
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_object_address = rsp_addr_ff;

endmodule
